// ===== sv/lsf_pkg.sv =====
package lsf_pkg;

  localparam int ADDR_BITS = 7;
  localparam int PC_BITS   = 6;

  typedef enum logic [1:0] {
    MODE_CMD   = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_OPEN  = 2'd2,
    MODE_NIB   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    SRC_ZERO = 3'd0,
    SRC_ONE  = 3'd1,
    SRC_CMD  = 3'd2,
    SRC_ADDR = 3'd3,
    SRC_NIB  = 3'd4
  } src_t;

  typedef enum logic [1:0] {
    END_NONE     = 2'd0,
    END_ALWAYS   = 2'd1,
    END_IF_CLOSE = 2'd2
  } end_t;

  typedef enum logic [1:0] {
    RUN_KEEP         = 2'd0,
    RUN_SET          = 2'd1,
    RUN_CLR          = 2'd2,
    RUN_CLR_IF_CLOSE = 2'd3
  } run_t;

  // One microcode word: where the bit comes from and what happens around it
  typedef struct packed {
    src_t       src;
    logic [2:0] sel;
    logic       start;
    logic       fin;
    end_t       endk;
    run_t       run_op;
  } ctrl_t;

  // One serial bit handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    logic data_bit;
    logic frame_start;
    logic frame_end;
    logic last;
  } bit_t;

  localparam logic [PC_BITS-1:0] ENTRY_CMD   = 6'd0;
  localparam logic [PC_BITS-1:0] ENTRY_WRITE = 6'd12;
  localparam logic [PC_BITS-1:0] ENTRY_OPEN  = 6'd26;
  localparam logic [PC_BITS-1:0] ENTRY_NIB   = 6'd36;

  function automatic logic [PC_BITS-1:0] entry_of(mode_t m);
    logic [PC_BITS-1:0] e;
    unique case (m)
      MODE_CMD:   e = ENTRY_CMD;
      MODE_WRITE: e = ENTRY_WRITE;
      MODE_OPEN:  e = ENTRY_OPEN;
      default:    e = ENTRY_NIB;
    endcase
    return e;
  endfunction

  function automatic ctrl_t mk(src_t s, int sel, logic st, logic fn, end_t ek, run_t ro);
    ctrl_t w;
    w.src    = s;
    w.sel    = 3'(sel);
    w.start  = st;
    w.fin    = fn;
    w.endk   = ek;
    w.run_op = ro;
    return w;
  endfunction

  // Microcode table: command, single write, open run, run nibble
  function automatic ctrl_t rom_word(logic [PC_BITS-1:0] pc);
    ctrl_t w;
    int    p;
    p = int'(pc);
    case (pc) inside
      6'd0, 6'd12, 6'd26: w = mk(SRC_ONE, 0, 1'b1, 1'b0, END_NONE, RUN_KEEP);
      6'd1, 6'd2, 6'd13, 6'd27:
        w = mk(SRC_ZERO, 0, 1'b0, 1'b0, END_NONE, RUN_KEEP);
      6'd14, 6'd28:  w = mk(SRC_ONE, 0, 1'b0, 1'b0, END_NONE, RUN_KEEP);
      [6'd3:6'd10]:  w = mk(SRC_CMD, 10 - p, 1'b0, 1'b0, END_NONE, RUN_KEEP);
      6'd11:         w = mk(SRC_ZERO, 0, 1'b0, 1'b1, END_ALWAYS, RUN_CLR);
      [6'd15:6'd21]: w = mk(SRC_ADDR, 21 - p, 1'b0, 1'b0, END_NONE, RUN_KEEP);
      [6'd22:6'd24]: w = mk(SRC_NIB, p - 22, 1'b0, 1'b0, END_NONE, RUN_KEEP);
      6'd25:         w = mk(SRC_NIB, 3, 1'b0, 1'b1, END_ALWAYS, RUN_CLR);
      [6'd29:6'd34]: w = mk(SRC_ADDR, 35 - p, 1'b0, 1'b0, END_NONE, RUN_KEEP);
      6'd35:         w = mk(SRC_ADDR, 0, 1'b0, 1'b1, END_NONE, RUN_SET);
      [6'd36:6'd38]: w = mk(SRC_NIB, p - 36, 1'b0, 1'b0, END_NONE, RUN_KEEP);
      6'd39:         w = mk(SRC_NIB, 3, 1'b0, 1'b1, END_IF_CLOSE, RUN_CLR_IF_CLOSE);
      default:       w = mk(SRC_ZERO, 0, 1'b0, 1'b1, END_NONE, RUN_KEEP);
    endcase
    return w;
  endfunction

endpackage

// ===== sv/lsf_seq.sv =====
module lsf_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [1:0]                   mode,
  input  logic [7:0]                   command_code,
  input  logic [lsf_pkg::ADDR_BITS-1:0] address,
  input  logic [3:0]                   nibble,
  input  logic                         close_run,
  input  logic                         advance,
  output logic                         busy,
  output lsf_pkg::bit_t                bit_o
);
  import lsf_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 run_open_r, run_open_nxt;
  logic [PC_BITS-1:0]   pc_r, pc_nxt;
  logic [7:0]           cmd_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [3:0]           nib_r;
  logic                 close_r;
  ctrl_t                cw;
  logic                 dbit;
  mode_t                mode_in;

  assign mode_in = mode_t'(mode);
  assign cw      = rom_word(pc_r);
  assign busy    = busy_r;

  always_comb begin
    case (cw.src)
      SRC_ONE:  dbit = 1'b1;
      SRC_CMD:  dbit = cmd_r[cw.sel];
      SRC_ADDR: dbit = addr_r[cw.sel];
      SRC_NIB:  dbit = nib_r[cw.sel[1:0]];
      default:  dbit = 1'b0;
    endcase
  end

  always_comb begin
    bit_o.valid       = busy_r;
    bit_o.data_bit    = dbit;
    bit_o.frame_start = cw.start;
    bit_o.frame_end   = (cw.endk == END_ALWAYS) || (cw.endk == END_IF_CLOSE && close_r);
    bit_o.last        = cw.fin;
  end

  always_comb begin
    busy_nxt     = busy_r;
    run_open_nxt = run_open_r;
    pc_nxt       = pc_r;
    if (start) begin
      // a run nibble with no open run produces nothing
      busy_nxt = (mode_in != MODE_NIB) || run_open_r;
      pc_nxt   = entry_of(mode_in);
    end else if (busy_r && advance) begin
      pc_nxt = pc_r + 1'b1;
      if (cw.fin) begin
        busy_nxt = 1'b0;
        case (cw.run_op)
          RUN_SET:          run_open_nxt = 1'b1;
          RUN_CLR:          run_open_nxt = 1'b0;
          RUN_CLR_IF_CLOSE: run_open_nxt = run_open_r & ~close_r;
          default:          run_open_nxt = run_open_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      run_open_r <= 1'b0;
      pc_r       <= '0;
    end else begin
      busy_r     <= busy_nxt;
      run_open_r <= run_open_nxt;
      pc_r       <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r   <= command_code;
      addr_r  <= address;
      nib_r   <= nibble;
      close_r <= close_run;
    end
  end

endmodule

// ===== sv/led_driver_serial_framer.sv =====
// Channel | Direction | Handshake        | Payload
// in_     | input     | in_valid/in_stall | mode, command_code, address, nibble, close_run
// out_    | output    | out_valid/out_stall | data_bit, frame_start, frame_end, last
//
// One request at a time; the microcode sequencer steps through one serial bit per word.
// After a transaction is taken, in_stall stays high until its last bit has left the
// sequencer; a run nibble with no open run holds nothing and leaves in_stall low.
// Reset (rst_n low, synchronous) idles the sequencer and closes any write run.
// A stall on out_ freezes the sequencer with the pending bit held in the output register.
module led_driver_serial_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_command_code,
  input  logic [lsf_pkg::ADDR_BITS-1:0] in_address,
  input  logic [3:0]                    in_nibble,
  input  logic                          in_close_run,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_data_bit,
  output logic                          out_frame_start,
  output logic                          out_frame_end,
  output logic                          out_last
);
  import lsf_pkg::*;

  logic  busy;
  logic  in_take;
  logic  advance;
  bit_t  seq_bit;

  logic  out_valid_r, out_valid_nxt;
  logic  data_bit_r, frame_start_r, frame_end_r, last_r;

  // Take a new transaction only when the sequencer is idle
  assign in_stall = busy;
  assign in_take  = in_valid & ~busy;

  // Advance the microcode when the output register is free or being emptied
  assign advance = ~out_valid_r | ~out_stall;

  lsf_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_take),
    .mode         (in_mode),
    .command_code (in_command_code),
    .address      (in_address),
    .nibble       (in_nibble),
    .close_run    (in_close_run),
    .advance      (advance),
    .busy         (busy),
    .bit_o        (seq_bit)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = seq_bit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled; load a fresh bit on each advance
  always_ff @(posedge clk) begin
    if (advance && seq_bit.valid) begin
      data_bit_r    <= seq_bit.data_bit;
      frame_start_r <= seq_bit.frame_start;
      frame_end_r   <= seq_bit.frame_end;
      last_r        <= seq_bit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_bit    = data_bit_r;
  assign out_frame_start = frame_start_r;
  assign out_frame_end   = frame_end_r;
  assign out_last        = last_r;

endmodule

// ===== tb/sv/tb_led_driver_serial_framer.sv =====
// One serial bit as the framer presents it on the out_ channel
typedef struct packed {
  logic data_bit;
  logic frame_start;
  logic frame_end;
  logic last;
} serial_bit_t;

class frame_scoreboard;
  serial_bit_t pending_bits[$];
  logic        run_open;
  int          errors;
  int          bits_checked;
  int          silent_nibbles;
  int          requests[4];

  function new();
    run_open       = 1'b0;
    errors         = 0;
    bits_checked   = 0;
    silent_nibbles = 0;
    foreach (requests[i]) requests[i] = 0;
  endfunction

  function int pending();
    return pending_bits.size();
  endfunction

  function void push_bit(logic d, logic s);
    serial_bit_t b;
    b.data_bit    = d;
    b.frame_start = s;
    b.frame_end   = 1'b0;
    b.last        = 1'b0;
    pending_bits.push_back(b);
  endfunction

  function void push_msb(logic [7:0] v, int n, logic s);
    for (int i = n - 1; i >= 0; i--) begin
      push_bit(v[i], s);
      s = 1'b0;
    end
  endfunction

  function void push_lsb4(logic [3:0] v);
    for (int i = 0; i < 4; i++) push_bit(v[i], 1'b0);
  endfunction

  // Build the bit frame of one accepted request; returns the number of bits
  function int note_request(lsf_pkg::mode_t m, logic [7:0] cmd,
                            logic [lsf_pkg::ADDR_BITS-1:0] addr, logic [3:0] nib,
                            logic cls);
    int          first;
    logic        ends;
    serial_bit_t tail;
    first = pending_bits.size();
    ends  = 1'b0;
    requests[int'(m)]++;
    case (m)
      lsf_pkg::MODE_CMD: begin
        push_msb(8'h04, 3, 1'b1);
        push_msb(cmd, 8, 1'b0);
        push_bit(1'b0, 1'b0);
        ends     = 1'b1;
        run_open = 1'b0;
      end
      lsf_pkg::MODE_WRITE: begin
        push_msb(8'h05, 3, 1'b1);
        push_msb(8'(addr), lsf_pkg::ADDR_BITS, 1'b0);
        push_lsb4(nib);
        ends     = 1'b1;
        run_open = 1'b0;
      end
      lsf_pkg::MODE_OPEN: begin
        push_msb(8'h05, 3, 1'b1);
        push_msb(8'(addr), lsf_pkg::ADDR_BITS, 1'b0);
        run_open = 1'b1;
      end
      default: begin
        if (!run_open) begin
          silent_nibbles++;
          return 0;
        end
        push_lsb4(nib);
        if (cls) begin
          ends     = 1'b1;
          run_open = 1'b0;
        end
      end
    endcase
    tail           = pending_bits.pop_back();
    tail.frame_end = ends;
    tail.last      = 1'b1;
    pending_bits.push_back(tail);
    return pending_bits.size() - first;
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 100) $display("MISMATCH: %s", msg);
  endtask

  task check_bit(logic d, logic fs, logic fe, logic l);
    serial_bit_t want;
    bits_checked++;
    if (pending_bits.size() == 0) begin
      report($sformatf("unexpected bit %0d: data=%b start=%b end=%b last=%b",
                       bits_checked, d, fs, fe, l));
      return;
    end
    want = pending_bits.pop_front();
    if (d !== want.data_bit)
      report($sformatf("bit %0d data_bit %b, want %b", bits_checked, d, want.data_bit));
    if (fs !== want.frame_start)
      report($sformatf("bit %0d frame_start %b, want %b", bits_checked, fs, want.frame_start));
    if (fe !== want.frame_end)
      report($sformatf("bit %0d frame_end %b, want %b", bits_checked, fe, want.frame_end));
    if (l !== want.last)
      report($sformatf("bit %0d last %b, want %b", bits_checked, l, want.last));
  endtask
endclass

module tb_led_driver_serial_framer;
  import lsf_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 190;
  localparam int CALM_ITEMS   = 30;     // final stretch with no idling on either side
  localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;     // settle time once nothing is expected
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_mode = 2'd0;
  logic [7:0]           in_command_code = 8'd0;
  logic [ADDR_BITS-1:0] in_address = '0;
  logic [3:0]           in_nibble = 4'd0;
  logic                 in_close_run = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_data_bit;
  logic                 out_frame_start;
  logic                 out_frame_end;
  logic                 out_last;

  frame_scoreboard sb;

  // Pacing controls shared between the sender and the receiver
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_req   = 1'b0;
  int   n_framed   = 0;     // accepted requests that produced at least one bit
  int   cycle_count = 0;

  led_driver_serial_framer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_command_code (in_command_code),
    .in_address      (in_address),
    .in_nibble       (in_nibble),
    .in_close_run    (in_close_run),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_bit    (out_data_bit),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: give up well beyond the slowest legal run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Offer one request and hold it until the framer takes it. Values sampled at
  // the edge are the pre-edge ones, so in_stall here is what the DUT saw.
  task automatic send_item(mode_t m, logic [7:0] cmd, logic [ADDR_BITS-1:0] addr,
                           logic [3:0] nib, logic cls);
    int gap;
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_command_code <= cmd;
    in_address      <= addr;
    in_nibble       <= nib;
    in_close_run    <= cls;
    do @(posedge clk); while (in_stall);
    // Transaction accepted: extend the expected bit stream
    if (sb.note_request(m, cmd, addr, nib, cls) > 0) n_framed++;
    // Drop valid for a random burst now and then, so gaps land on every phase
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Shorthands with random content in the fields a mode ignores
  task automatic send_cmd(logic [7:0] cmd);
    send_item(MODE_CMD, cmd, ADDR_BITS'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic send_write(logic [ADDR_BITS-1:0] addr, logic [3:0] nib);
    send_item(MODE_WRITE, 8'($urandom), addr, nib, 1'($urandom));
  endtask

  task automatic send_open(logic [ADDR_BITS-1:0] addr);
    send_item(MODE_OPEN, 8'($urandom), addr, 4'($urandom), 1'($urandom));
  endtask

  task automatic send_nib(logic [3:0] nib, logic cls);
    send_item(MODE_NIB, 8'($urandom), ADDR_BITS'($urandom), nib, cls);
  endtask

  // Receiver pacing: stall bursts, idle-free stretches, and one long hold-off
  initial begin : rx_pacing
    int span;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        span = $urandom_range(1, 15);
        out_stall <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Compare each accepted bit with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_bit(out_data_bit, out_frame_start, out_frame_end, out_last);
  end

  initial begin : stimulus
    int   kind;
    int   runlen;
    int   base;
    int   done;
    logic hold_started;
    logic drained;
    logic broken;
    sb = new();
    hold_started = 1'b0;
    drained      = 1'b0;

    // Hold reset at the start, then release it once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every mode, and the run corner cases
    send_cmd(8'h00);
    send_cmd(8'hFF);
    send_cmd(8'hA5);
    send_write('0, 4'h0);
    send_write('1, 4'hF);
    send_write(ADDR_BITS'(7'h55), 4'hA);
    send_nib(4'hF, 1'b0);               // stray run nibble, nothing comes out
    send_nib(4'h6, 1'b1);               // stray closing nibble, still nothing
    send_open('1);
    send_nib(4'hF, 1'b0);
    send_nib(4'h0, 1'b0);
    send_nib(4'h9, 1'b1);               // closes the run
    send_nib(4'h3, 1'b0);               // run already closed
    send_open('0);
    send_open(ADDR_BITS'(7'h2A));       // restart the run at a new address
    send_nib(4'h5, 1'b0);
    send_cmd(8'h3C);                    // command abandons the open run
    send_nib(4'hC, 1'b1);
    send_open(ADDR_BITS'(7'h11));
    send_write(ADDR_BITS'(7'h22), 4'h6); // single write abandons the run
    send_nib(4'h1, 1'b1);

    // Random: mostly well-formed frames and runs, with stray and broken ones
    base = n_framed;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done >= RANDOM_ITEMS - CALM_ITEMS) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      // Long hold-off: keep offering while the receiver refuses everything
      if (!hold_started && done >= 50) begin
        hold_started = 1'b1;
        hold_req     = 1'b1;
      end
      // Pause the sender until every expected bit has drained
      if (!drained && done >= 120) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          runlen = $urandom_range(1, 6);
          broken = ($urandom_range(0, 5) == 0);
          send_open(ADDR_BITS'($urandom));
          for (int i = 0; i < runlen; i++)
            send_nib(4'($urandom), (i == runlen - 1) && !broken);
        end
        4, 5:    send_write(ADDR_BITS'($urandom), 4'($urandom));
        6, 7:    send_cmd(8'($urandom));
        8:       send_nib(4'($urandom), 1'($urandom));
        default: begin
          // Open a run and cut it short with a fresh frame
          send_open(ADDR_BITS'($urandom));
          if ($urandom_range(0, 1) == 0) send_open(ADDR_BITS'($urandom));
          else send_cmd(8'($urandom));
        end
      endcase
      done = n_framed - base;
    end
    in_valid <= 1'b0;

    // Wait for the last bits, then a little longer for anything unexpected
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands, %0d single writes, %0d run opens, %0d run nibbles",
             sb.requests[MODE_CMD], sb.requests[MODE_WRITE], sb.requests[MODE_OPEN],
             sb.requests[MODE_NIB]);
    $display("(%0d of them with no run open) and %0d serial bits in %0d cycles",
             sb.silent_nibbles, sb.bits_checked, cycle_count);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
